// File: rtl/core/ptds_pkg.sv
// Shared types and constants of the periodic transmit deadline scheduler.
package ptds_pkg;

    localparam int unsigned CATEGORIES_DEF     = 4;
    localparam int unsigned TELEMETRY_SLOT_DEF = 3;
    localparam int unsigned REG_CATS           = 4;
    localparam int unsigned TIME_W             = 32;
    localparam int unsigned PERIOD_W           = 31;
    localparam int unsigned PADDR_W            = 5;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request fields
        logic chk;        // check the configuration of the selected category
        logic seed;       // write first deadline of the selected category
        logic clear;      // clear the whole schedule
        logic activate;   // mark the schedule active
        logic upd;        // evaluate the selected category of an update
        logic div_go;     // start the remainder unit
        logic upd_done;   // write back an update after the remainder
        logic pop;        // examine the selected category for a pop
        logic tele;       // apply the telemetry mask
        logic [2:0] sel;  // selected category
    } ptds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       active;
        logic       cfg_bad;
        logic       reached;
        logic       div_busy;
        logic       pop_blocked;
        logic       pop_hit;
        logic       pop_pend;
    } ptds_sts_t;

endpackage

// File: rtl/core/ptds_div.sv
// Serial remainder unit, one quotient bit per cycle.
module ptds_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [ptds_pkg::TIME_W-1:0]   dividend,
    input  logic [ptds_pkg::PERIOD_W-1:0] divisor,
    output logic                          busy,
    output logic [ptds_pkg::TIME_W-1:0]   remainder
);
    logic [ptds_pkg::TIME_W-1:0] rem_reg, rem_next;
    logic [ptds_pkg::TIME_W-1:0] num_reg, num_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic [ptds_pkg::TIME_W:0]   shifted;
    logic [ptds_pkg::TIME_W:0]   diff;

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, num_reg[ptds_pkg::TIME_W-1]};
        diff      = shifted - {2'b00, divisor};
        if (go)
        begin
            rem_next  = '0;
            num_next  = dividend;
            cnt_next  = 6'(ptds_pkg::TIME_W);
            busy_next = (divisor != '0);
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[ptds_pkg::TIME_W-2:0], 1'b0};
            if (!diff[ptds_pkg::TIME_W])
                rem_next = diff[ptds_pkg::TIME_W-1:0];
            else
                rem_next = shifted[ptds_pkg::TIME_W-1:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;
endmodule

// File: rtl/core/ptds_datapath.sv
// Schedule state, configuration registers and per-category arithmetic.
module ptds_datapath #(
    parameter int unsigned CATEGORIES     = ptds_pkg::CATEGORIES_DEF,
    parameter int unsigned TELEMETRY_SLOT = ptds_pkg::TELEMETRY_SLOT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptds_pkg::ptds_cmd_t           cmd,
    output ptds_pkg::ptds_sts_t           sts,
    input  logic [1:0]                    opcode,
    input  logic [ptds_pkg::TIME_W-1:0]   now_ms,
    input  logic                          telemetry_on,
    input  logic                          cfg_wr,
    input  logic [2:0]                    cfg_idx,
    input  logic [ptds_pkg::PERIOD_W-1:0] cfg_data,
    input  logic [2:0]                    rd_idx,
    output logic [ptds_pkg::PERIOD_W-1:0] rd_data,
    output logic [3:0]                    pending_bits
);
    localparam int unsigned RC = ptds_pkg::REG_CATS;
    localparam int unsigned TW = ptds_pkg::TIME_W;
    localparam int unsigned PW = ptds_pkg::PERIOD_W;
    localparam int unsigned IW = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam logic [TW-1:0] HALF = {1'b1, {(TW-1){1'b0}}};

    logic [PW-1:0] period_reg [RC];
    logic [PW-1:0] phase_reg  [RC];
    logic [PW-1:0] pcopy_reg  [CATEGORIES];
    logic [TW-1:0] next_reg   [CATEGORIES];
    logic [TW-1:0] rel_reg    [CATEGORIES];
    logic [CATEGORIES-1:0] pend_reg;
    logic          active_reg;
    logic [TW-1:0] last_reg;
    logic          grec_reg;
    logic [1:0]    op_reg;
    logic [TW-1:0] now_reg;
    logic          tele_reg;

    logic [2:0]    sel;
    logic [IW-1:0] idx;
    logic [PW-1:0] p_sel, cfg_p, cfg_ph;
    logic [TW-1:0] d_sel, r_sel, elapsed, latest, lat_age, rel_age;
    logic          div_busy;
    logic [TW-1:0] rem;
    logic          lat_stale, rel_stale;
    logic [PW-1:0] rd_data_int;

    assign sel    = cmd.sel;
    assign idx    = sel[IW-1:0];
    assign p_sel  = pcopy_reg[idx];
    assign d_sel  = next_reg[idx];
    assign r_sel  = rel_reg[idx];
    assign cfg_p  = (32'(sel) < RC) ? period_reg[sel[1:0]] : '0;
    assign cfg_ph = (32'(sel) < RC) ? phase_reg[sel[1:0]] : '0;

    assign elapsed   = now_reg - d_sel;
    assign latest    = now_reg - rem;
    assign lat_age   = rem;
    assign rel_age   = now_reg - r_sel;
    assign lat_stale = (lat_age < HALF) && (lat_age > TW'(p_sel >> 1));
    assign rel_stale = (rel_age < HALF) && (rel_age > TW'(p_sel >> 1));

    ptds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (elapsed),
        .divisor   (p_sel),
        .busy      (div_busy),
        .remainder (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RC; i++)
            begin
                period_reg[i] <= '0;
                phase_reg[i]  <= '0;
            end
            for (int i = 0; i < CATEGORIES; i++)
            begin
                pcopy_reg[i] <= '0;
                next_reg[i]  <= '0;
                rel_reg[i]   <= '0;
            end
            pend_reg   <= '0;
            active_reg <= 1'b0;
            last_reg   <= '0;
            grec_reg   <= 1'b0;
            op_reg     <= '0;
            now_reg    <= '0;
            tele_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_idx[2])
                    phase_reg[cfg_idx[1:0]] <= cfg_data;
                else
                    period_reg[cfg_idx[1:0]] <= cfg_data;
            end
            if (cmd.load)
            begin
                op_reg   <= opcode;
                now_reg  <= now_ms;
                tele_reg <= telemetry_on;
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < CATEGORIES; i++)
                begin
                    pcopy_reg[i] <= '0;
                    next_reg[i]  <= '0;
                    rel_reg[i]   <= '0;
                end
                pend_reg   <= '0;
                active_reg <= 1'b0;
                last_reg   <= '0;
                grec_reg   <= 1'b0;
            end
            if (cmd.seed)
            begin
                pcopy_reg[idx] <= cfg_p;
                next_reg[idx]  <= now_reg + TW'(cfg_ph);
            end
            if (cmd.activate)
                active_reg <= 1'b1;
            if (cmd.upd && !sts.reached && pend_reg[idx] && rel_stale)
                pend_reg[idx] <= 1'b0;
            if (cmd.upd_done)
            begin
                next_reg[idx] <= latest + TW'(p_sel);
                rel_reg[idx]  <= latest;
                pend_reg[idx] <= !lat_stale;
            end
            if (cmd.tele && !tele_reg && (TELEMETRY_SLOT < CATEGORIES))
                pend_reg[TELEMETRY_SLOT % CATEGORIES] <= 1'b0;
            if (cmd.pop && pend_reg[idx])
            begin
                pend_reg[idx] <= 1'b0;
                if (!rel_stale)
                begin
                    last_reg <= now_reg;
                    grec_reg <= 1'b1;
                end
            end
        end
    end

    // Elapsed time below half range means the deadline has been reached;
    // the remainder is then (now - d) mod p, and the latest release is now - rem.
    assign sts.op          = op_reg;
    assign sts.active      = active_reg;
    assign sts.cfg_bad     = (cfg_p == '0) || (cfg_ph >= cfg_p);
    assign sts.reached     = elapsed < HALF;
    assign sts.div_busy    = div_busy;
    assign sts.pop_blocked = !active_reg || (grec_reg && last_reg == now_reg);
    assign sts.pop_pend    = pend_reg[idx];
    assign sts.pop_hit     = pend_reg[idx] && !rel_stale;

    assign rd_data      = rd_data_int;
    assign pending_bits = 4'(pend_reg);

    always_comb
    begin
        if (rd_idx[2])
            rd_data_int = phase_reg[rd_idx[1:0]];
        else
            rd_data_int = period_reg[rd_idx[1:0]];
    end
endmodule

// File: rtl/core/ptds_ctrl.sv
// Sequencing controller of the scheduler.
module ptds_ctrl #(
    parameter int unsigned CATEGORIES = ptds_pkg::CATEGORIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output ptds_pkg::ptds_cmd_t cmd,
    input  ptds_pkg::ptds_sts_t sts,
    output logic                start_ok,
    output logic                granted,
    output logic [1:0]          granted_category
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CHK, S_SEED, S_UPD, S_DIV, S_WB, S_POP, S_DONE, S_OUT
    } state_t;

    localparam logic [2:0] LAST = 3'(CATEGORIES - 1);

    state_t     state_reg;
    logic [2:0] sel_reg;
    logic       ok_reg, gr_reg;
    logic [1:0] cat_reg;

    always_comb
    begin
        cmd       = '0;
        cmd.sel   = sel_reg;
        cmd.load  = (state_reg == S_IDLE) && in_valid;
        cmd.chk   = (state_reg == S_CHK);
        cmd.clear = (state_reg == S_CHK) && (sel_reg == 3'd0);
        cmd.seed  = (state_reg == S_SEED);
        cmd.activate = (state_reg == S_SEED) && (sel_reg == LAST);
        cmd.upd   = (state_reg == S_UPD);
        cmd.div_go = (state_reg == S_UPD) && sts.reached;
        cmd.upd_done = (state_reg == S_WB);
        cmd.tele  = (state_reg == S_DONE) && (sts.op == ptds_pkg::OP_UPDATE) && sts.active;
        cmd.pop   = (state_reg == S_POP);
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = (state_reg == S_OUT);
    assign start_ok         = ok_reg;
    assign granted          = gr_reg;
    assign granted_category = cat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            ok_reg    <= 1'b0;
            gr_reg    <= 1'b0;
            cat_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    sel_reg <= '0;
                    if (in_valid)
                        state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    ok_reg  <= 1'b0;
                    gr_reg  <= 1'b0;
                    cat_reg <= '0;
                    unique case (sts.op)
                        ptds_pkg::OP_START:  state_reg <= S_CHK;
                        ptds_pkg::OP_UPDATE: state_reg <= sts.active ? S_UPD : S_OUT;
                        ptds_pkg::OP_POP:
                            state_reg <= sts.pop_blocked ? S_OUT : S_POP;
                        default:             state_reg <= S_OUT;
                    endcase
                end
                S_CHK:
                begin
                    if (sts.cfg_bad)
                        state_reg <= S_OUT;
                    else if (sel_reg == LAST)
                    begin
                        sel_reg   <= '0;
                        state_reg <= S_SEED;
                    end
                    else
                        sel_reg <= sel_reg + 3'd1;
                end
                S_SEED:
                begin
                    if (sel_reg == LAST)
                    begin
                        ok_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        sel_reg <= sel_reg + 3'd1;
                end
                S_UPD:
                begin
                    if (sts.reached)
                        state_reg <= S_DIV;
                    else if (sel_reg == LAST)
                        state_reg <= S_DONE;
                    else
                        sel_reg <= sel_reg + 3'd1;
                end
                S_DIV:
                begin
                    if (!sts.div_busy)
                        state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (sel_reg == LAST)
                        state_reg <= S_DONE;
                    else
                    begin
                        sel_reg   <= sel_reg + 3'd1;
                        state_reg <= S_UPD;
                    end
                end
                S_POP:
                begin
                    if (sts.pop_hit)
                    begin
                        gr_reg    <= 1'b1;
                        cat_reg   <= sel_reg[1:0];
                        state_reg <= S_OUT;
                    end
                    else if (sel_reg == LAST)
                        state_reg <= S_OUT;
                    else
                        sel_reg <= sel_reg + 3'd1;
                end
                S_DONE:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/periodic_tx_deadline_scheduler.sv
// Periodic transmit deadline scheduler, top level.
// One request at a time. An update is paced by the shared serial remainder
// unit, which retires one bit of (now - deadline) mod period per cycle for
// each category whose deadline has been reached. Periods and phases are to be
// written through the APB port only while the block is idle, which the block
// itself does not enforce; they are read back there.
module periodic_tx_deadline_scheduler #(
    parameter int unsigned CATEGORIES     = ptds_pkg::CATEGORIES_DEF,
    parameter int unsigned TELEMETRY_SLOT = ptds_pkg::TELEMETRY_SLOT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptds_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [31:0]                  now_ms,
    input  logic                         telemetry_on,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         start_ok,
    output logic                         granted,
    output logic [1:0]                   granted_category,
    output logic [3:0]                   pending_bits
);
    ptds_pkg::ptds_cmd_t cmd;
    ptds_pkg::ptds_sts_t sts;
    logic [ptds_pkg::PERIOD_W-1:0] rd_data;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[4:2] <= 3'd7);
    assign prdata = {1'b0, rd_data};

    ptds_ctrl #(.CATEGORIES(CATEGORIES)) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cmd              (cmd),
        .sts              (sts),
        .start_ok         (start_ok),
        .granted          (granted),
        .granted_category (granted_category)
    );

    ptds_datapath #(
        .CATEGORIES     (CATEGORIES),
        .TELEMETRY_SLOT (TELEMETRY_SLOT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .now_ms       (now_ms),
        .telemetry_on (telemetry_on),
        .cfg_wr       (cfg_wr),
        .cfg_idx      (paddr[4:2]),
        .cfg_data     (pwdata[30:0]),
        .rd_idx       (paddr[4:2]),
        .rd_data      (rd_data),
        .pending_bits (pending_bits)
    );
endmodule

// File: bench/periodic_tx_deadline_scheduler_test.sv
// Self-checking testbench for the periodic transmit deadline scheduler.
`timescale 1ns / 1ps

module periodic_tx_deadline_scheduler_test;

    localparam int NUM_CATS = 4;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int REG_PERIOD0 = 0;
    localparam int REG_PHASE0 = 4;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic       start_ok;
        logic       granted;
        logic [1:0] category;
        logic [3:0] pending;
    } sched_result_t;

    class sched_scoreboard;
        logic [30:0]   period_reg[NUM_CATS];
        logic [30:0]   phase_reg[NUM_CATS];
        logic          running;
        logic [30:0]   period_copy[NUM_CATS];
        logic [31:0]   next_due[NUM_CATS];
        logic [31:0]   release_at[NUM_CATS];
        logic [3:0]    pending;
        logic [31:0]   last_grant;
        logic          grant_seen;
        sched_result_t expected_q[$];
        int            mismatches;

        function new();
            for (int c = 0; c < NUM_CATS; c++)
            begin
                period_reg[c] = '0;
                phase_reg[c] = '0;
            end
            mismatches = 0;
            clear_schedule();
        endfunction

        function void clear_schedule();
            running = 1'b0;
            for (int c = 0; c < NUM_CATS; c++)
            begin
                period_copy[c] = '0;
                next_due[c] = '0;
                release_at[c] = '0;
            end
            pending = '0;
            last_grant = '0;
            grant_seen = 1'b0;
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            if (idx < NUM_CATS)
                period_reg[idx] = value[30:0];
            else
                phase_reg[idx - NUM_CATS] = value[30:0];
        endfunction

        function bit is_stale(logic [31:0] now, logic [31:0] t, logic [30:0] p);
            logic [31:0] age;
            age = now - t;
            return !age[31] && (age > {1'b0, p} / 2);
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] now, logic tele);
            sched_result_t r;
            logic [31:0] elapsed;
            logic [31:0] rem;
            logic [31:0] latest;
            bit ok;
            r = '0;
            if (op == ptds_pkg::OP_START)
            begin
                clear_schedule();
                ok = 1;
                for (int c = 0; c < NUM_CATS; c++)
                    if (period_reg[c] == 0 || phase_reg[c] >= period_reg[c])
                        ok = 0;
                if (ok)
                begin
                    for (int c = 0; c < NUM_CATS; c++)
                    begin
                        period_copy[c] = period_reg[c];
                        next_due[c] = now + {1'b0, phase_reg[c]};
                    end
                    running = 1'b1;
                end
                r.start_ok = ok;
            end
            else if (op == ptds_pkg::OP_UPDATE && running)
            begin
                for (int c = 0; c < NUM_CATS; c++)
                begin
                    elapsed = now - next_due[c];
                    if (!elapsed[31])
                    begin
                        rem = (period_copy[c] != 0) ? elapsed % {1'b0, period_copy[c]} : 0;
                        latest = next_due[c] + (elapsed - rem);
                        next_due[c] = latest + {1'b0, period_copy[c]};
                        release_at[c] = latest;
                        pending[c] = !is_stale(now, latest, period_copy[c]);
                    end
                    else if (pending[c] && is_stale(now, release_at[c], period_copy[c]))
                        pending[c] = 1'b0;
                    if (c == 3 && !tele)
                        pending[c] = 1'b0;
                end
            end
            else if (op == ptds_pkg::OP_POP && running && !(grant_seen && last_grant == now))
            begin
                for (int c = 0; c < NUM_CATS; c++)
                begin
                    if (pending[c])
                    begin
                        pending[c] = 1'b0;
                        if (!is_stale(now, release_at[c], period_copy[c]))
                        begin
                            last_grant = now;
                            grant_seen = 1'b1;
                            r.granted = 1'b1;
                            r.category = c[1:0];
                            break;
                        end
                    end
                end
            end
            r.pending = pending;
            expected_q.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected ok=%b gr=%b cat=%0d pend=%b, got ok=%b gr=%b cat=%0d pend=%b",
                             want.start_ok, want.granted, want.category, want.pending,
                             got.start_ok, got.granted, got.category, got.pending);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ptds_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [31:0] now_ms = '0;
    logic        telemetry_on = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        start_ok;
    logic        granted;
    logic [1:0]  granted_category;
    logic [3:0]  pending_bits;

    sched_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    logic [31:0] clock_ms = '0;

    periodic_tx_deadline_scheduler u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .now_ms(now_ms), .telemetry_on(telemetry_on),
        .out_valid(out_valid), .out_stall(out_stall),
        .start_ok(start_ok), .granted(granted),
        .granted_category(granted_category), .pending_bits(pending_bits)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({start_ok, granted, granted_category, pending_bits});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic write_reg(int idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ptds_pkg::PADDR_W'(4 * idx);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Waits for all expected results, then lets a long update finish.
    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_request(logic [1:0] op, logic [31:0] now, logic tele);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        now_ms <= now;
        telemetry_on <= tele;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(op, now, tele);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic configure(logic [30:0] base, logic [30:0] spread);
        logic [30:0] p;
        for (int c = 0; c < NUM_CATS; c++)
        begin
            p = base + 31'($urandom_range(spread));
            if (p == 0)
                p = 1;
            write_reg(REG_PERIOD0 + c, {1'b0, p});
            write_reg(REG_PHASE0 + c, {1'b0, 31'($urandom) % p});
        end
    endtask

    // Mostly start then a run of updates and pops on a slowly advancing clock.
    task automatic random_burst(int count);
        logic [1:0] op;
        int r;
        clock_ms = $urandom;
        send_request(ptds_pkg::OP_START, clock_ms, 1'b1);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                clock_ms = $urandom;
            else if (r < 70)
                clock_ms = clock_ms + $urandom_range(6);
            op = (r < 45) ? ptds_pkg::OP_UPDATE : (r < 90) ? ptds_pkg::OP_POP :
                 (r < 93) ? OP_NONE : ptds_pkg::OP_START;
            send_request(op, clock_ms, $urandom_range(99) < 80);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: inactive ops, bad configurations, edges of time and periods.
        send_request(ptds_pkg::OP_UPDATE, 32'd5, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'd5, 1'b1);
        send_request(ptds_pkg::OP_START, 32'd0, 1'b0);
        send_request(OP_NONE, 32'hFFFF_FFFF, 1'b1);
        drain();
        for (int c = 0; c < NUM_CATS; c++)
        begin
            write_reg(REG_PERIOD0 + c, 32'd4 + c);
            write_reg(REG_PHASE0 + c, c);
        end
        write_reg(REG_PHASE0 + 2, 32'd6);
        send_request(ptds_pkg::OP_START, 32'd100, 1'b1);
        drain();
        write_reg(REG_PHASE0 + 2, 32'd2);
        send_request(ptds_pkg::OP_START, 32'hFFFF_FFFE, 1'b1);
        send_request(ptds_pkg::OP_UPDATE, 32'd3, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'd3, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'd3, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'd4, 1'b1);
        send_request(ptds_pkg::OP_UPDATE, 32'd4, 1'b0);
        send_request(ptds_pkg::OP_UPDATE, 32'd40, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'd41, 1'b1);
        send_request(ptds_pkg::OP_UPDATE, 32'h8000_0100, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'h8000_0101, 1'b1);
        drain();
        write_reg(REG_PERIOD0, 32'hFFFF_FFFF);
        write_reg(REG_PHASE0, 32'h7FFF_FFFE);
        send_request(ptds_pkg::OP_START, 32'd0, 1'b1);
        send_request(ptds_pkg::OP_UPDATE, 32'h7FFF_FFFF, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'h7FFF_FFFF, 1'b1);
        drain();
        write_reg(REG_PERIOD0, 32'd1);
        write_reg(REG_PHASE0, 32'd0);
        send_request(ptds_pkg::OP_START, 32'd7, 1'b1);
        send_request(ptds_pkg::OP_UPDATE, 32'd1000, 1'b1);
        send_request(ptds_pkg::OP_POP, 32'd1000, 1'b1);
        drain();

        // Random phases with different idling and period ranges.
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 36 : 59) : 0;
            recv_stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 36 : 0;
            case (ph % 3)
                0: configure(31'd1, 31'd12);
                1: configure(31'd2, 31'd60);
                default: configure(31'h7FFF_FF00, 31'hFF);
            endcase
            random_burst(52);
            drain();
        end

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: periodic_tx_deadline_scheduler.f
rtl/core/ptds_pkg.sv
rtl/core/ptds_div.sv
rtl/core/ptds_datapath.sv
rtl/core/ptds_ctrl.sv
rtl/core/periodic_tx_deadline_scheduler.sv
bench/periodic_tx_deadline_scheduler_test.sv
